/* src/spa_pkg.sv */
// Shared types and constants for the sparse polynomial adder.
// No dependencies; every other file of the block but spa_checker refers to it by scoped names.
package spa_pkg;

	// Store capacity per polynomial and derived index and count widths
	localparam int MAX_TERMS = 32;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);

	// Field widths
	localparam int COEF_W   = 32;
	localparam int EXP_BITS = 10;

	// Saturation limits of a Q16.16 coefficient
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	// Polynomial tag codes
	localparam logic POLY_A = 1'b0;
	localparam logic POLY_B = 1'b1;

	// One stored term
	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [EXP_BITS-1:0]      expo;
	} term_t;

	// Write request to a term store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		term_t            data;
	} store_wr_t;

	// Heads of both lists presented to the merge unit
	typedef struct packed {
		term_t head_a;
		term_t head_b;
		logic  a_ok;
		logic  b_ok;
	} merge_req_t;

	// Decision and result of the merge unit
	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [EXP_BITS-1:0]      expo;
		logic                     sat;
		logic                     take_a;
		logic                     take_b;
	} merge_res_t;

endpackage

/* src/spa_term_store.sv */
// Term store for one polynomial: single write port, one registered read port.
// Depends on spa_pkg for the entry type and depth.
module spa_term_store (
	input  logic                      clk,
	input  spa_pkg::store_wr_t        wr,
	input  logic [spa_pkg::IDX_W-1:0] rd_addr,
	output spa_pkg::term_t            rd_data
);

	spa_pkg::term_t mem_q [spa_pkg::MAX_TERMS];
	spa_pkg::term_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* src/spa_merge_unit.sv */
// Shared compare and saturating-add unit: picks the next merged term from two heads.
// Depends on spa_pkg for the request and result structs.
module spa_merge_unit (
	input  spa_pkg::merge_req_t req,
	output spa_pkg::merge_res_t res
);

	logic                              exp_eq;
	logic                              a_gt;
	logic signed [spa_pkg::COEF_W:0]   sum;
	logic                              ovf;

	assign exp_eq = req.head_a.expo == req.head_b.expo;
	assign a_gt   = req.head_a.expo > req.head_b.expo;

	// 33-bit sum is exact; overflow when the top two bits differ
	assign sum = {req.head_a.coef[spa_pkg::COEF_W-1], req.head_a.coef}
	           + {req.head_b.coef[spa_pkg::COEF_W-1], req.head_b.coef};
	assign ovf = sum[spa_pkg::COEF_W] != sum[spa_pkg::COEF_W-1];

	// Equal exponents add, otherwise the larger exponent goes first
	always_comb begin
		res = '0;
		if (req.a_ok && req.b_ok && exp_eq) begin
			res.expo   = req.head_a.expo;
			res.sat    = ovf;
			res.take_a = 1'b1;
			res.take_b = 1'b1;
			if (!ovf) begin
				res.coef = sum[spa_pkg::COEF_W-1:0];
			end else if (sum[spa_pkg::COEF_W]) begin
				res.coef = spa_pkg::COEF_MIN;
			end else begin
				res.coef = spa_pkg::COEF_MAX;
			end
		end else if (!req.b_ok || (req.a_ok && a_gt)) begin
			res.coef   = req.head_a.coef;
			res.expo   = req.head_a.expo;
			res.take_a = 1'b1;
		end else begin
			res.coef   = req.head_b.coef;
			res.expo   = req.head_b.expo;
			res.take_b = 1'b1;
		end
	end

endmodule

/* src/spa_sequencer.sv */
// Load and merge sequencer: fills the stores, then walks both lists through the
// merge unit and holds each result in the output register. Depends on spa_pkg.
module spa_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         which_poly,
	input  logic signed [31:0]           term_coefficient,
	input  logic [9:0]                   term_exponent,
	input  logic                         last_term,
	// stores
	output spa_pkg::store_wr_t           wr_a,
	output spa_pkg::store_wr_t           wr_b,
	output logic [spa_pkg::IDX_W-1:0]    rd_addr_a,
	output logic [spa_pkg::IDX_W-1:0]    rd_addr_b,
	input  spa_pkg::term_t               rd_data_a,
	input  spa_pkg::term_t               rd_data_b,
	// merge unit
	output spa_pkg::merge_req_t          mreq,
	input  spa_pkg::merge_res_t          mres,
	// output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [31:0]           sum_coefficient,
	output logic [9:0]                   sum_exponent,
	output logic                         saturated,
	output logic                         truncated,
	output logic                         last_result
);

	typedef enum logic [2:0] {
		S_LOAD = 3'b001,
		S_READ = 3'b010,
		S_CALC = 3'b100
	} state_t;

	localparam logic [spa_pkg::CNT_W-1:0] CNT_MAX = spa_pkg::CNT_W'(spa_pkg::MAX_TERMS);

	state_t                     state_q;
	logic [spa_pkg::CNT_W-1:0]  cnt_a_q, cnt_b_q;
	logic [spa_pkg::CNT_W-1:0]  idx_a_q, idx_b_q;
	logic                       done_a_q, done_b_q, dropped_q;

	logic                       out_valid_q;
	logic signed [31:0]         coef_q;
	logic [9:0]                 expo_q;
	logic                       sat_q, trunc_q, last_q;

	logic                       in_beat;
	logic                       sel_done, sel_full;
	logic [spa_pkg::CNT_W-1:0]  sel_cnt;
	logic                       both_done;
	logic                       slot_free;
	logic                       fire;
	logic [spa_pkg::CNT_W-1:0]  idx_a_n, idx_b_n;
	logic                       merge_last;
	spa_pkg::term_t             in_term;

	assign in_ready  = state_q == S_LOAD;
	assign in_beat   = in_valid && in_ready;
	assign sel_done  = (which_poly == spa_pkg::POLY_B) ? done_b_q : done_a_q;
	assign sel_cnt   = (which_poly == spa_pkg::POLY_B) ? cnt_b_q : cnt_a_q;
	assign sel_full  = sel_cnt >= CNT_MAX;
	assign both_done = ((which_poly == spa_pkg::POLY_A) ? last_term : done_a_q)
	                && ((which_poly == spa_pkg::POLY_B) ? last_term : done_b_q)
	                && !sel_done;

	assign in_term.coef = term_coefficient;
	assign in_term.expo = term_exponent[spa_pkg::EXP_BITS-1:0];

	// Store writes on an accepted beat for an open, non-full list
	always_comb begin
		wr_a      = '0;
		wr_b      = '0;
		wr_a.data = in_term;
		wr_b.data = in_term;
		wr_a.addr = cnt_a_q[spa_pkg::IDX_W-1:0];
		wr_b.addr = cnt_b_q[spa_pkg::IDX_W-1:0];
		wr_a.en   = in_beat && !sel_done && !sel_full && (which_poly == spa_pkg::POLY_A);
		wr_b.en   = in_beat && !sel_done && !sel_full && (which_poly == spa_pkg::POLY_B);
	end

	// Read addresses follow the list heads
	assign rd_addr_a = idx_a_q[spa_pkg::IDX_W-1:0];
	assign rd_addr_b = idx_b_q[spa_pkg::IDX_W-1:0];

	assign mreq.head_a = rd_data_a;
	assign mreq.head_b = rd_data_b;
	assign mreq.a_ok   = idx_a_q < cnt_a_q;
	assign mreq.b_ok   = idx_b_q < cnt_b_q;

	// Merge step fires when the output register is free or being emptied
	assign slot_free  = !out_valid_q || out_ready;
	assign fire       = (state_q == S_CALC) && slot_free;
	assign idx_a_n    = idx_a_q + spa_pkg::CNT_W'(mres.take_a);
	assign idx_b_n    = idx_b_q + spa_pkg::CNT_W'(mres.take_b);
	assign merge_last = !(idx_a_n < cnt_a_q) && !(idx_b_n < cnt_b_q);

	// Sequencer and list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			idx_a_q   <= '0;
			idx_b_q   <= '0;
			done_a_q  <= 1'b0;
			done_b_q  <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_beat && !sel_done) begin
						if (sel_full) begin
							dropped_q <= 1'b1;
						end else if (which_poly == spa_pkg::POLY_B) begin
							cnt_b_q <= cnt_b_q + spa_pkg::CNT_W'(1);
						end else begin
							cnt_a_q <= cnt_a_q + spa_pkg::CNT_W'(1);
						end
						if (last_term) begin
							if (which_poly == spa_pkg::POLY_B) begin
								done_b_q <= 1'b1;
							end else begin
								done_a_q <= 1'b1;
							end
						end
						if (both_done) begin
							idx_a_q <= '0;
							idx_b_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (fire) begin
						idx_a_q <= idx_a_n;
						idx_b_q <= idx_b_n;
						if (merge_last) begin
							cnt_a_q   <= '0;
							cnt_b_q   <= '0;
							done_a_q  <= 1'b0;
							done_b_q  <= 1'b0;
							dropped_q <= 1'b0;
							state_q   <= S_LOAD;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			coef_q  <= mres.coef;
			expo_q  <= 10'(mres.expo);
			sat_q   <= mres.sat;
			trunc_q <= merge_last && dropped_q;
			last_q  <= merge_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign sum_coefficient = coef_q;
	assign sum_exponent    = expo_q;
	assign saturated       = sat_q;
	assign truncated       = trunc_q;
	assign last_result     = last_q;

endmodule

/* src/sparse_polynomial_adder_core.sv */
// Top level of the sparse polynomial adder: two term stores, sequencer, merge unit.
// Depends on spa_pkg, spa_term_store, spa_merge_unit and spa_sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | which_poly, term_coefficient, term_exponent,
//          |                      | last_term
//  out     | out_valid/ out_ready | sum_coefficient, sum_exponent, saturated,
//          |                      | truncated, last_result
//
// Loading accepts one term beat per cycle. After the beat that closes both lists the
// merge produces each result through a store read step, then a compare/add step,
// because the read port of the term stores is registered; in_ready is low during merge.
// Reset clears counts, flags and the sequencer; the stores are not cleared and are
// only read where written. A stalled result holds the merge in its compare step.
module sparse_polynomial_adder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               which_poly,
	input  logic signed [31:0] term_coefficient,
	input  logic [9:0]         term_exponent,
	input  logic               last_term,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sum_coefficient,
	output logic [9:0]         sum_exponent,
	output logic               saturated,
	output logic               truncated,
	output logic               last_result
);

	spa_pkg::store_wr_t            wr_a, wr_b;
	logic [spa_pkg::IDX_W-1:0]     rd_addr_a, rd_addr_b;
	spa_pkg::term_t                rd_data_a, rd_data_b;
	spa_pkg::merge_req_t           mreq;
	spa_pkg::merge_res_t           mres;

	spa_term_store u_store_a (
		.clk     (clk),
		.wr      (wr_a),
		.rd_addr (rd_addr_a),
		.rd_data (rd_data_a)
	);

	spa_term_store u_store_b (
		.clk     (clk),
		.wr      (wr_b),
		.rd_addr (rd_addr_b),
		.rd_data (rd_data_b)
	);

	spa_merge_unit u_merge (
		.req (mreq),
		.res (mres)
	);

	spa_sequencer u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.which_poly       (which_poly),
		.term_coefficient (term_coefficient),
		.term_exponent    (term_exponent),
		.last_term        (last_term),
		.wr_a             (wr_a),
		.wr_b             (wr_b),
		.rd_addr_a        (rd_addr_a),
		.rd_addr_b        (rd_addr_b),
		.rd_data_a        (rd_data_a),
		.rd_data_b        (rd_data_b),
		.mreq             (mreq),
		.mres             (mres),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sum_coefficient  (sum_coefficient),
		.sum_exponent     (sum_exponent),
		.saturated        (saturated),
		.truncated        (truncated),
		.last_result      (last_result)
	);

endmodule

/* src/spa_checker.sv */
// Port-level checks for the sparse polynomial adder, bound to the top level.
// Depends on sparse_polynomial_adder_core's port list only.
module spa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] sum_coefficient,
	input logic [9:0]         sum_exponent,
	input logic               saturated,
	input logic               truncated,
	input logic               last_result
);

	// A stalled result beat stays valid
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its coefficient, exponent and last_result
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sum_coefficient) && $stable(sum_exponent)
			&& $stable(last_result))
		else $error("result payload changed while stalled");

	// A saturated sum sits on one of the two limits
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (sum_coefficient == 32'sh7FFF_FFFF)
			|| (sum_coefficient == 32'sh8000_0000))
		else $error("saturated flag without clamped coefficient");

	// Truncation is only reported on the final beat
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> last_result)
		else $error("truncated flag on a non-final beat");

	// No new term is taken while a non-final result of a merge waits
	a_no_load_mid_merge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> !in_ready)
		else $error("input ready in the middle of a merge");

endmodule

bind sparse_polynomial_adder_core spa_checker u_spa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.sum_coefficient (sum_coefficient),
	.sum_exponent    (sum_exponent),
	.saturated       (saturated),
	.truncated       (truncated),
	.last_result     (last_result)
);

/* bench/tb_sparse_polynomial_adder_core.sv */
// Self-checking bench for sparse_polynomial_adder_core: loads pairs of term lists and
// checks every merged term against a model of the exponent merge kept in the bench.
// Depends on spa_pkg and the sparse_polynomial_adder_core RTL.
module tb_sparse_polynomial_adder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned ITEM_TARGET = 160;
	localparam int unsigned TAIL_START  = 130;
	localparam int unsigned DRAIN_WAIT  = 40;

	// One merged term as the block should present it
	typedef struct {
		logic signed [31:0] coef;
		logic [9:0]         expo;
		logic               sat;
		logic               trunc;
		logic               last;
	} sum_term_t;

	// Predicts the merge of both term lists and checks the result beats in order
	class term_sum_scoreboard;
		spa_pkg::term_t store_a [spa_pkg::MAX_TERMS];
		spa_pkg::term_t store_b [spa_pkg::MAX_TERMS];
		int unsigned    cnt_a, cnt_b;
		bit             closed_a, closed_b, lost_terms;
		sum_term_t      sums_due [$];
		int unsigned    errors, merges, results, sat_seen, trunc_seen;

		function int unsigned pending();
			return sums_due.size();
		endfunction

		// Accepted term beat: store it, and merge once both lists are closed
		function void note_term(logic which, logic signed [31:0] coef, logic [9:0] expo,
				logic last);
			int unsigned i, j;
			logic [32:0] wide;
			sum_term_t   r;
			if (which == spa_pkg::POLY_A) begin
				if (!closed_a) begin
					if (cnt_a < spa_pkg::MAX_TERMS) begin
						store_a[cnt_a].coef = coef;
						store_a[cnt_a].expo = expo;
						cnt_a++;
					end else begin
						lost_terms = 1'b1;
					end
					if (last)
						closed_a = 1'b1;
				end
			end else begin
				if (!closed_b) begin
					if (cnt_b < spa_pkg::MAX_TERMS) begin
						store_b[cnt_b].coef = coef;
						store_b[cnt_b].expo = expo;
						cnt_b++;
					end else begin
						lost_terms = 1'b1;
					end
					if (last)
						closed_b = 1'b1;
				end
			end
			if (!(closed_a && closed_b))
				return;

			// Merge the heads as they stand, highest exponent first
			i = 0;
			j = 0;
			while (i < cnt_a || j < cnt_b) begin
				r.trunc = 1'b0;
				r.last  = 1'b0;
				if (i < cnt_a && j < cnt_b && store_a[i].expo == store_b[j].expo) begin
					wide = {store_a[i].coef[31], store_a[i].coef}
						+ {store_b[j].coef[31], store_b[j].coef};
					if (wide[32] != wide[31]) begin
						r.coef = wide[32] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
						r.sat  = 1'b1;
					end else begin
						r.coef = wide[31:0];
						r.sat  = 1'b0;
					end
					r.expo = store_a[i].expo;
					i++;
					j++;
				end else if (j >= cnt_b || (i < cnt_a && store_a[i].expo > store_b[j].expo)) begin
					r.coef = store_a[i].coef;
					r.expo = store_a[i].expo;
					r.sat  = 1'b0;
					i++;
				end else begin
					r.coef = store_b[j].coef;
					r.expo = store_b[j].expo;
					r.sat  = 1'b0;
					j++;
				end
				sums_due.push_back(r);
			end
			sums_due[sums_due.size() - 1].trunc = lost_terms;
			sums_due[sums_due.size() - 1].last  = 1'b1;
			merges++;
			cnt_a      = 0;
			cnt_b      = 0;
			closed_a   = 1'b0;
			closed_b   = 1'b0;
			lost_terms = 1'b0;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Accepted result beat: compare with the oldest outstanding term
		function void check_sum(logic signed [31:0] coef, logic [9:0] expo, logic sat,
				logic trunc, logic last);
			sum_term_t want;
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got coef %0h exp %0d",
					$time, coef, expo);
				errors++;
				return;
			end
			want = sums_due.pop_front();
			results++;
			if (want.sat)
				sat_seen++;
			if (want.trunc)
				trunc_seen++;
			compare_field("sum_coefficient", want.coef, coef);
			compare_field("sum_exponent", 32'(want.expo), 32'(expo));
			compare_field("saturated", 32'(want.sat), 32'(sat));
			compare_field("truncated", 32'(want.trunc), 32'(trunc));
			compare_field("last_result", 32'(want.last), 32'(last));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               which_poly;
	logic signed [31:0] term_coefficient;
	logic [9:0]         term_exponent;
	logic               last_term;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] sum_coefficient;
	logic [9:0]         sum_exponent;
	logic               saturated;
	logic               truncated;
	logic               last_result;

	term_sum_scoreboard sb;
	bit                 tail_phase;
	int unsigned        hold_requests;
	int unsigned        terms_sent;

	sparse_polynomial_adder_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.which_poly       (which_poly),
		.term_coefficient (term_coefficient),
		.term_exponent    (term_exponent),
		.last_term        (last_term),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sum_coefficient  (sum_coefficient),
		.sum_exponent     (sum_exponent),
		.saturated        (saturated),
		.truncated        (truncated),
		.last_result      (last_result)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_term(which_poly, term_coefficient, term_exponent, last_term);
			if (out_valid && out_ready)
				sb.check_sum(sum_coefficient, sum_exponent, saturated, truncated, last_result);
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
			STALL_LIMIT, sb.pending());
		$display("tb_sparse_polynomial_adder_core: done, errors");
		$finish;
	end

	// Result sink: random stall bursts, plus one long hold on request
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left    = 0;
		holds_served = 0;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Coefficient mix: extremes, zero, minus one, small, near-limit and full random
	function automatic logic signed [31:0] pick_coef();
		logic [15:0] frac;
		frac = 16'($urandom_range(0, 16'hFFFF));
		case ($urandom_range(0, 7))
			0: return spa_pkg::COEF_MAX;
			1: return spa_pkg::COEF_MIN;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return {{16{frac[15]}}, frac};
			5: return spa_pkg::COEF_MAX - $urandom_range(0, 255);
			6: return spa_pkg::COEF_MIN + $urandom_range(0, 255);
			default: return $urandom();
		endcase
	endfunction

	// Offer one term beat and hold it until accepted; may idle first
	task automatic send_term(input logic which, input logic signed [31:0] coef,
			input logic [9:0] expo, input logic last, input bit no_gaps);
		if (!no_gaps && !tail_phase && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		which_poly       <= which;
		term_coefficient <= coef;
		term_exponent    <= expo;
		last_term        <= last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// One pair of polynomials: descending exponents, some shared, randomly interleaved.
	// A messy pair breaks the order now and then and sends stray terms to a closed list.
	task automatic run_pair(input int unsigned n_steps, input bit messy, input bit dense,
			input bit no_gaps);
		spa_pkg::term_t list_a [$];
		spa_pkg::term_t list_b [$];
		spa_pkg::term_t t;
		int unsigned    cursor, step_max, step, kind, k, ia, ib;
		logic           side;
		cursor   = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(n_steps, 1023);
		step_max = (1023 / n_steps > 1) ? 1023 / n_steps : 1;
		for (k = 0; k < n_steps; k++) begin
			kind = dense ? 2 : $urandom_range(0, 2);
			if (kind != 1) begin
				t.coef = pick_coef();
				t.expo = (messy && $urandom_range(0, 3) == 0) ?
					10'($urandom_range(0, 1023)) : 10'(cursor);
				list_a.push_back(t);
			end
			if (kind != 0) begin
				t.coef = pick_coef();
				t.expo = (messy && $urandom_range(0, 3) == 0) ?
					10'($urandom_range(0, 1023)) : 10'(cursor);
				list_b.push_back(t);
			end
			step   = $urandom_range(1, step_max);
			cursor = (cursor > step) ? cursor - step : 0;
		end
		// both lists need at least one term to close
		if (list_a.size() == 0) begin
			t.coef = pick_coef();
			t.expo = 10'(cursor);
			list_a.push_back(t);
		end
		if (list_b.size() == 0) begin
			t.coef = pick_coef();
			t.expo = 10'(cursor);
			list_b.push_back(t);
		end

		ia = 0;
		ib = 0;
		while (ia < list_a.size() || ib < list_b.size()) begin
			if (ia >= list_a.size())
				side = spa_pkg::POLY_B;
			else if (ib >= list_b.size())
				side = spa_pkg::POLY_A;
			else
				side = $urandom_range(0, 1) ? spa_pkg::POLY_B : spa_pkg::POLY_A;
			if (side == spa_pkg::POLY_A) begin
				send_term(spa_pkg::POLY_A, list_a[ia].coef, list_a[ia].expo,
					ia == list_a.size() - 1, no_gaps);
				ia++;
			end else begin
				send_term(spa_pkg::POLY_B, list_b[ib].coef, list_b[ib].expo,
					ib == list_b.size() - 1, no_gaps);
				ib++;
			end
			terms_sent++;
			// stray beat to a list that is already closed while the other is open
			if (messy && $urandom_range(0, 3) == 0) begin
				if (ia == list_a.size() && ib < list_b.size())
					send_term(spa_pkg::POLY_A, pick_coef(), 10'($urandom_range(0, 1023)),
						1'($urandom_range(0, 1)), no_gaps);
				else if (ib == list_b.size() && ia < list_a.size())
					send_term(spa_pkg::POLY_B, pick_coef(), 10'($urandom_range(0, 1023)),
						1'($urandom_range(0, 1)), no_gaps);
			end
		end
	endtask

	// Stimulus and end of run
	initial begin : stimulus
		int unsigned pair_no;
		sb               = new();
		tail_phase       = 1'b0;
		hold_requests    = 0;
		terms_sent       = 0;
		pair_no          = 0;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		which_poly       <= spa_pkg::POLY_A;
		term_coefficient <= '0;
		term_exponent    <= '0;
		last_term        <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Saturation both ways, zero sum kept, stray term to closed A, B closes last
		send_term(spa_pkg::POLY_A, spa_pkg::COEF_MAX, 10'd1023, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_B, 32'sd1, 10'd1023, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_A, spa_pkg::COEF_MIN, 10'd512, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_B, spa_pkg::COEF_MIN, 10'd512, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_A, 32'sh0005_0000, 10'd300, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_B, -32'sh0005_0000, 10'd300, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_A, 32'sh0001_0000, 10'd0, 1'b1, 1'b0);
		send_term(spa_pkg::POLY_A, 32'sh1234_5678, 10'd7, 1'b1, 1'b0);
		send_term(spa_pkg::POLY_B, spa_pkg::COEF_MAX, 10'd1, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_B, -32'sd1, 10'd0, 1'b1, 1'b0);

		// B closes first and out of order, stray term to closed B, repeated exponent in A
		send_term(spa_pkg::POLY_B, 32'sh0000_8000, 10'd5, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_B, spa_pkg::COEF_MAX, 10'd900, 1'b1, 1'b0);
		send_term(spa_pkg::POLY_B, spa_pkg::COEF_MIN, 10'd44, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_A, spa_pkg::COEF_MAX, 10'd900, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_A, -32'sh0000_8000, 10'd5, 1'b0, 1'b0);
		send_term(spa_pkg::POLY_A, 32'sh7FFF_0000, 10'd5, 1'b1, 1'b0);

		// Single-term lists: alternating bit patterns, then zero against minus one
		send_term(spa_pkg::POLY_A, 32'sh5555_5555, 10'h2AA, 1'b1, 1'b0);
		send_term(spa_pkg::POLY_B, 32'shAAAA_AAAA, 10'h155, 1'b1, 1'b0);
		send_term(spa_pkg::POLY_B, -32'sd1, 10'd1023, 1'b1, 1'b0);
		send_term(spa_pkg::POLY_A, 32'sd0, 10'd0, 1'b1, 1'b0);
		terms_sent += 18;

		// hold the sender until the block has drained
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);

		// Random pairs; one overfull pair merges against a long receiver hold
		while (terms_sent < ITEM_TARGET) begin
			if (terms_sent >= TAIL_START)
				tail_phase = 1'b1;
			if (pair_no == 3) begin
				hold_requests++;
				run_pair(36, 1'b0, 1'b1, 1'b1);
			end else begin
				run_pair($urandom_range(1, 8), $urandom_range(0, 3) == 0, 1'b0,
					$urandom_range(0, 3) == 0);
			end
			pair_no++;
		end

		// Drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run: %0d term beats in %0d merges, %0d merged terms checked,",
			terms_sent, sb.merges, sb.results);
		$display("     %0d clamped sums, %0d merges with dropped terms, %0d mismatches",
			sb.sat_seen, sb.trunc_seen, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_sparse_polynomial_adder_core: done, clean");
		else
			$display("tb_sparse_polynomial_adder_core: done, errors");
		$finish;
	end
endmodule
